// ===== rtl/tod_pkg.sv =====
`default_nettype none

package tod_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_MODE        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_TILT         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STABLE_TIME_MS   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL_MS = 2'd3;

	// screen (x, y) from sensor (a, b)
	typedef enum logic [2:0] {
		AXIS_A_B   = 3'd0,
		AXIS_B_A   = 3'd1,
		AXIS_NB_A  = 3'd2,
		AXIS_B_NA  = 3'd3,
		AXIS_NA_NB = 3'd4,
		AXIS_NA_B  = 3'd5,
		AXIS_A_NB  = 3'd6,
		AXIS_NB_NA = 3'd7
	} axis_mode_t;

	localparam logic [2:0] CLASS_ROT0      = 3'd0;
	localparam logic [2:0] CLASS_ROT1      = 3'd1;
	localparam logic [2:0] CLASS_ROT2      = 3'd2;
	localparam logic [2:0] CLASS_ROT3      = 3'd3;
	localparam logic [2:0] CLASS_AMBIGUOUS = 3'd4;

	localparam axis_mode_t  RST_AXIS_MODE        = AXIS_A_B;
	localparam logic [15:0] RST_MIN_TILT         = 16'd4096;
	localparam logic [15:0] RST_STABLE_TIME_MS   = 16'd300;
	localparam logic [15:0] RST_POLL_INTERVAL_MS = 16'd100;

endpackage

`default_nettype wire

// ===== rtl/tod_ifs.sv =====
`default_nettype none

interface tod_smp_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] accel_x;
	logic signed [15:0] accel_y;
	logic        [31:0] time_ms;

	modport source (output valid, accel_x, accel_y, time_ms, input ready);
	modport sink   (input valid, accel_x, accel_y, time_ms, output ready);
endinterface

interface tod_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] rotation;
	logic       rotation_changed;
	logic       sample_taken;
	logic [2:0] target_class;

	modport source (output valid, rotation, rotation_changed, sample_taken, target_class,
		input ready);
	modport sink   (input valid, rotation, rotation_changed, sample_taken, target_class,
		output ready);
endinterface

interface tod_cfg_if import tod_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tod_classify.sv =====
`default_nettype none

module tod_classify import tod_pkg::*; (
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  axis_mode_t         axis_mode,
	input  logic        [15:0] min_tilt,
	output logic        [2:0]  target_class
);

	// 17 bits so that negating -32768 stays exact
	logic signed [16:0] a, b, na, nb, x, y;
	logic        [16:0] mag_x, mag_y;
	logic        [16:0] thr;
	logic               y_pos, x_pos;

	assign a   = {accel_x[15], accel_x};
	assign b   = {accel_y[15], accel_y};
	assign na  = -a;
	assign nb  = -b;
	assign thr = {1'b0, min_tilt};

	always_comb begin
		unique case (axis_mode)
			AXIS_A_B:   begin x = a;  y = b;  end
			AXIS_B_A:   begin x = b;  y = a;  end
			AXIS_NB_A:  begin x = nb; y = a;  end
			AXIS_B_NA:  begin x = b;  y = na; end
			AXIS_NA_NB: begin x = na; y = nb; end
			AXIS_NA_B:  begin x = na; y = b;  end
			AXIS_A_NB:  begin x = a;  y = nb; end
			AXIS_NB_NA: begin x = nb; y = na; end
			default:    begin x = a;  y = b;  end
		endcase
	end

	assign mag_x = x[16] ? 17'(-x) : 17'(x);
	assign mag_y = y[16] ? 17'(-y) : 17'(y);
	assign x_pos = !x[16] && (x != 17'sd0);
	assign y_pos = !y[16] && (y != 17'sd0);

	always_comb begin
		priority if (mag_x < thr && mag_y < thr) begin
			target_class = CLASS_AMBIGUOUS;
		end else if (mag_y > mag_x) begin
			target_class = y_pos ? CLASS_ROT3 : CLASS_ROT1;
		end else begin
			target_class = x_pos ? CLASS_ROT0 : CLASS_ROT2;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/tilt_orientation_debouncer_core.sv =====
// channel  dir  handshake     beat
// smp      in   valid/ready   accel_x, accel_y (s16), time_ms (u32)
// res      out  valid/ready   rotation, rotation_changed, sample_taken, target_class
// cfg      in   valid/ready   index (2 b), data (16 b); ready is always high
//
// one sample per cycle sustained while res is ready; an smp beat reaches the res beat
// through the input register, then classify and debounce into the result register
// the debounce state updates in the same cycle a sample moves into the result register
// a stalled res stage holds one result and one more sample in the input register
// arst_n clears valids, state and configuration to their reset values
`default_nettype none

module tilt_orientation_debouncer_core import tod_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tod_smp_if.sink    smp,
	tod_res_if.source  res,
	tod_cfg_if.sink    cfg
);

	// configuration
	axis_mode_t  axis_mode_q;
	logic [15:0] min_tilt_q;
	logic [15:0] stable_time_ms_q;
	logic [15:0] poll_interval_ms_q;

	// debounce state
	logic [1:0]  committed_q;
	logic [1:0]  candidate_q;
	logic [31:0] candidate_start_q;
	logic [31:0] last_taken_q;

	// input stage
	logic               valid_s1;
	logic signed [15:0] accel_x_s1;
	logic signed [15:0] accel_y_s1;
	logic        [31:0] time_ms_s1;

	// result stage
	logic       valid_s2;
	logic [1:0] rotation_s2;
	logic       changed_s2;
	logic       taken_s2;
	logic [2:0] class_s2;

	logic       advance;
	logic       taken;
	logic       ambiguous;
	logic       do_commit;
	logic [2:0] cls;
	logic [31:0] since_taken;
	logic [31:0] since_start;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_mode_q        <= RST_AXIS_MODE;
			min_tilt_q         <= RST_MIN_TILT;
			stable_time_ms_q   <= RST_STABLE_TIME_MS;
			poll_interval_ms_q <= RST_POLL_INTERVAL_MS;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_AXIS_MODE:        axis_mode_q        <= axis_mode_t'(cfg.data[2:0]);
				CFG_MIN_TILT:         min_tilt_q         <= cfg.data;
				CFG_STABLE_TIME_MS:   stable_time_ms_q   <= cfg.data;
				CFG_POLL_INTERVAL_MS: poll_interval_ms_q <= cfg.data;
				default:              ;
			endcase
		end
	end

	assign advance   = valid_s1 && (!valid_s2 || res.ready);
	assign smp.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (smp.ready) begin
			valid_s1 <= smp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (smp.ready && smp.valid) begin
			accel_x_s1 <= smp.accel_x;
			accel_y_s1 <= smp.accel_y;
			time_ms_s1 <= smp.time_ms;
		end
	end

	tod_classify u_classify (
		.accel_x      (accel_x_s1),
		.accel_y      (accel_y_s1),
		.axis_mode    (axis_mode_q),
		.min_tilt     (min_tilt_q),
		.target_class (cls)
	);

	// wrapping differences
	assign since_taken = time_ms_s1 - last_taken_q;
	assign since_start = time_ms_s1 - candidate_start_q;
	assign taken       = since_taken >= {16'd0, poll_interval_ms_q};
	assign ambiguous   = cls == CLASS_AMBIGUOUS;
	assign do_commit   = taken && !ambiguous && cls[1:0] != committed_q &&
		cls[1:0] == candidate_q && since_start >= {16'd0, stable_time_ms_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q       <= 2'd0;
			candidate_q       <= 2'd0;
			candidate_start_q <= 32'd0;
			last_taken_q      <= 32'd0;
		end else if (advance && taken) begin
			last_taken_q <= time_ms_s1;
			priority if (ambiguous || cls[1:0] == committed_q) begin
				candidate_q <= committed_q;
			end else if (cls[1:0] != candidate_q) begin
				candidate_q       <= cls[1:0];
				candidate_start_q <= time_ms_s1;
			end else begin
				// same candidate again: commit once it has held long enough
				if (do_commit) begin
					committed_q <= cls[1:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (res.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rotation_s2 <= do_commit ? cls[1:0] : committed_q;
			changed_s2  <= do_commit;
			taken_s2    <= taken;
			class_s2    <= taken ? cls : CLASS_AMBIGUOUS;
		end
	end

	assign res.valid            = valid_s2;
	assign res.rotation         = rotation_s2;
	assign res.rotation_changed = changed_s2;
	assign res.sample_taken     = taken_s2;
	assign res.target_class     = class_s2;

	// a skipped sample never commits and is never classified
	a_skip_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !taken_s2 |-> !changed_s2 && class_s2 == CLASS_AMBIGUOUS)
		else $error("skipped sample reports a class or a commit");

	// a commit reports the class that was committed
	a_commit_class: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && changed_s2 |-> rotation_s2 == class_s2[1:0])
		else $error("committed rotation differs from sample class");

	// the committed rotation moves only together with a changed beat
	a_commit_flag: assert property (@(posedge clk) disable iff (!arst_n)
		committed_q != $past(committed_q) |-> valid_s2 && changed_s2 &&
			rotation_s2 == committed_q)
		else $error("committed rotation moved without a changed beat");

	// a held sample is not dropped
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(time_ms_s1))
		else $error("input register lost a stalled sample");

endmodule

`default_nettype wire
